/* sv/tciu_pkg.sv */
// Shared types and constants of the timer compare interrupt unit.
`timescale 1ns / 1ps
`default_nettype none

package tciu_pkg;

    // Item kinds carried in the input tuser
    localparam logic [3:0] KIND_STEP      = 4'd0;
    localparam logic [3:0] KIND_CTL_WR    = 4'd1;
    localparam logic [3:0] KIND_CNT_HI_WR = 4'd2;
    localparam logic [3:0] KIND_CNT_LO_WR = 4'd3;
    localparam logic [3:0] KIND_CNT_HI_RD = 4'd4;
    localparam logic [3:0] KIND_NMI       = 4'd5;
    localparam logic [3:0] KIND_CMP_HI_WR = 4'd6;
    localparam logic [3:0] KIND_CMP_LO_WR = 4'd7;
    localparam logic [3:0] KIND_CMP_ACK   = 4'd8;
    localparam logic [3:0] KIND_WAIT      = 4'd9;
    localparam logic [3:0] KIND_SLEEP     = 4'd10;
    localparam logic [3:0] KIND_T2_CTL_WR = 4'd11;

    // Taken vector codes
    localparam logic [1:0] VEC_NONE = 2'd0;
    localparam logic [1:0] VEC_OCR  = 2'd1;
    localparam logic [1:0] VEC_NMI  = 2'd2;

    // Reset values and register masks
    localparam logic [7:0]  TCTL_RESET     = 8'h00;
    localparam logic [15:0] CNT_RESET      = 16'h0000;
    localparam logic [15:0] CMP_RESET      = 16'hFFFF;
    localparam logic [7:0]  T2CTL_RESET    = 8'h10;
    localparam logic [15:0] CNT_HI_PRESET  = 16'hFFF8;
    localparam logic [7:0]  TCTL_WR_MASK   = 8'h1F;
    localparam logic [7:0]  TCTL_KEEP_MASK = 8'hD0;
    localparam logic [7:0]  TCTL_RD_MASK   = 8'hDF;
    localparam logic [15:0] CMP_ACK_MASK   = 16'hBFFF;
    localparam logic [7:0]  T2CTL_WR_MASK  = 8'h0F;
    localparam logic [7:0]  T2CTL_SET      = 8'h10;
    localparam int unsigned TCTL_ENABLE_BIT = 3;
    localparam logic [3:0]  MAX_CYCLES     = 4'd12;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data;
        logic       irq_masked;
        logic [3:0] instr_cycles;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] vector_taken;
        logic       push_frame;
        logic       run_instruction;
        logic [3:0] cycles_used;
        logic       compare_pending;
        logic       nmi_pending_out;
    } result_t;

endpackage

`default_nettype wire

/* sv/tciu_core.sv */
// Timer and interrupt state with the single-pass update for one item.
`timescale 1ns / 1ps
`default_nettype none

module tciu_core
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              fire,
    input  tciu_pkg::item_t  item,
    output tciu_pkg::result_t result
);

    logic [7:0]  timer_control_reg,  timer_control_next;
    logic [15:0] free_counter_reg,   free_counter_next;
    logic [15:0] compare_value_reg,  compare_value_next;
    logic [7:0]  high_latch_reg,     high_latch_next;
    logic [7:0]  timer2_control_reg, timer2_control_next;
    logic        nmi_pending_reg,    nmi_pending_next;
    logic        ocr_pending_reg,    ocr_pending_next;
    logic [1:0]  wait_mode_reg,      wait_mode_next;

    logic [3:0]  icyc;
    logic        take_irq;
    logic [15:0] cnt_sum;

    // Saturate the instruction cycle count
    assign icyc = (item.instr_cycles > tciu_pkg::MAX_CYCLES) ? tciu_pkg::MAX_CYCLES
                                                             : item.instr_cycles;
    assign take_irq = (nmi_pending_reg || ocr_pending_reg) && !item.irq_masked;

    // Next state and result for the item in the input register
    always_comb
    begin
        timer_control_next  = timer_control_reg;
        free_counter_next   = free_counter_reg;
        compare_value_next  = compare_value_reg;
        high_latch_next     = high_latch_reg;
        timer2_control_next = timer2_control_reg;
        nmi_pending_next    = nmi_pending_reg;
        ocr_pending_next    = ocr_pending_reg;
        wait_mode_next      = wait_mode_reg;
        result              = '0;
        cnt_sum             = free_counter_reg;

        case (item.kind)
            tciu_pkg::KIND_STEP:
            begin
                if (take_irq)
                begin
                    if (ocr_pending_reg)
                    begin
                        ocr_pending_next    = 1'b0;
                        result.vector_taken = tciu_pkg::VEC_OCR;
                    end
                    else
                    begin
                        nmi_pending_next    = 1'b0;
                        result.vector_taken = tciu_pkg::VEC_NMI;
                    end
                    // sleep is dropped; a waiting CPU already stacked its frame
                    result.push_frame  = !wait_mode_reg[0];
                    wait_mode_next     = 2'b00;
                    result.cycles_used = 4'd1;
                end
                else if (wait_mode_reg != 2'b00)
                begin
                    result.cycles_used = 4'd1;
                end
                else
                begin
                    result.run_instruction = 1'b1;
                    result.cycles_used     = icyc;
                end
                // free counter advance and compare match
                cnt_sum = free_counter_reg + {12'd0, result.cycles_used};
                if (timer_control_reg[tciu_pkg::TCTL_ENABLE_BIT])
                begin
                    if (cnt_sum >= compare_value_reg)
                    begin
                        free_counter_next = cnt_sum - compare_value_reg;
                        ocr_pending_next  = 1'b1;
                    end
                    else
                    begin
                        free_counter_next = cnt_sum;
                    end
                end
            end
            tciu_pkg::KIND_CTL_WR:
            begin
                timer_control_next = (item.data & tciu_pkg::TCTL_WR_MASK)
                                   | (timer_control_reg & tciu_pkg::TCTL_KEEP_MASK);
            end
            tciu_pkg::KIND_CNT_HI_WR:
            begin
                high_latch_next   = item.data;
                free_counter_next = tciu_pkg::CNT_HI_PRESET;
            end
            tciu_pkg::KIND_CNT_LO_WR:
            begin
                free_counter_next = {high_latch_reg, item.data};
            end
            tciu_pkg::KIND_CNT_HI_RD:
            begin
                timer_control_next = timer_control_reg & tciu_pkg::TCTL_RD_MASK;
                result.read_data   = free_counter_reg[15:8];
            end
            tciu_pkg::KIND_NMI:
            begin
                nmi_pending_next = 1'b1;
            end
            tciu_pkg::KIND_CMP_HI_WR:
            begin
                compare_value_next = {item.data, compare_value_reg[7:0]};
            end
            tciu_pkg::KIND_CMP_LO_WR:
            begin
                compare_value_next = {compare_value_reg[15:8], item.data};
            end
            tciu_pkg::KIND_CMP_ACK:
            begin
                compare_value_next = compare_value_reg & tciu_pkg::CMP_ACK_MASK;
            end
            tciu_pkg::KIND_WAIT:
            begin
                wait_mode_next = wait_mode_reg | 2'b01;
            end
            tciu_pkg::KIND_SLEEP:
            begin
                wait_mode_next = wait_mode_reg | 2'b10;
            end
            tciu_pkg::KIND_T2_CTL_WR:
            begin
                timer2_control_next = (item.data & tciu_pkg::T2CTL_WR_MASK)
                                    | tciu_pkg::T2CTL_SET
                                    | (timer2_control_reg & tciu_pkg::TCTL_KEEP_MASK);
            end
            default:
            begin
            end
        endcase

        result.compare_pending = ocr_pending_next;
        result.nmi_pending_out = nmi_pending_next;
    end

    // State registers, updated once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_control_reg  <= tciu_pkg::TCTL_RESET;
            free_counter_reg   <= tciu_pkg::CNT_RESET;
            compare_value_reg  <= tciu_pkg::CMP_RESET;
            high_latch_reg     <= 8'h00;
            timer2_control_reg <= tciu_pkg::T2CTL_RESET;
            nmi_pending_reg    <= 1'b0;
            ocr_pending_reg    <= 1'b0;
            wait_mode_reg      <= 2'b00;
        end
        else if (fire)
        begin
            timer_control_reg  <= timer_control_next;
            free_counter_reg   <= free_counter_next;
            compare_value_reg  <= compare_value_next;
            high_latch_reg     <= high_latch_next;
            timer2_control_reg <= timer2_control_next;
            nmi_pending_reg    <= nmi_pending_next;
            ocr_pending_reg    <= ocr_pending_next;
            wait_mode_reg      <= wait_mode_next;
        end
    end

endmodule

`default_nettype wire

/* sv/timer_compare_interrupt_unit.sv */
// Top level: input register, state update and output register of the timer unit.
// Usage:
//   One stream in, one stream out. Each input beat is one instruction slot
//   (step) or one timer register access, selected by s_axis_tuser. Every input
//   beat yields exactly one output beat, in order.
//   Path: an accepted beat sits in the input register, is processed against the
//   timer state as it moves into the output register and shows on m_axis
//   from then on. Throughput: one beat per cycle while m_axis_tready is high;
//   the state update is one 16-bit add, compare and subtract between the
//   input and output registers.
//   Stall: when m_axis_tready is low the output register holds its beat, the
//   input register holds one more, and s_axis_tready drops only when both are
//   full. No beat is lost or repeated.
//   Reset (rst_n low, asynchronous): both registers empty, timer control 0x00,
//   counter 0x0000, compare 0xFFFF, timer 2 control 0x10, nothing pending,
//   neither waiting nor sleeping. The unit accepts beats from the first cycle.
`timescale 1ns / 1ps
`default_nettype none

module timer_compare_interrupt_unit
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [15:0] s_axis_tdata,  // data[7:0], irq_masked[8], instr_cycles[12:9], zero pad
    input  wire [3:0]  s_axis_tuser,  // kind[3:0]
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    // read_data[7:0], vector_taken[9:8], push_frame[10], run_instruction[11],
    // cycles_used[15:12], compare_pending[16], nmi_pending_out[17], zero pad
    output logic [23:0] m_axis_tdata
);

    logic              in_valid_reg;
    logic              in_valid_next;
    tciu_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    tciu_pkg::result_t out_result_reg;
    tciu_pkg::result_t core_result;
    logic              fire;

    // Process the held beat whenever the output register is free or draining
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    assign in_valid_next  = (s_axis_tvalid && s_axis_tready) || (in_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && !m_axis_tready);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.kind         <= s_axis_tuser;
            in_item_reg.data         <= s_axis_tdata[7:0];
            in_item_reg.irq_masked   <= s_axis_tdata[8];
            in_item_reg.instr_cycles <= s_axis_tdata[12:9];
        end
    end

    tciu_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .result (core_result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_result_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0,
                            out_result_reg.nmi_pending_out,
                            out_result_reg.compare_pending,
                            out_result_reg.cycles_used,
                            out_result_reg.run_instruction,
                            out_result_reg.push_frame,
                            out_result_reg.vector_taken,
                            out_result_reg.read_data};

    // A taken interrupt reports cycles_used of 1 and runs no instruction
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_result_reg.vector_taken != tciu_pkg::VEC_NONE)
        |-> (out_result_reg.cycles_used == 4'd1 && !out_result_reg.run_instruction))
        else $error("taken interrupt with wrong cycle cost or instruction run");

    // Stacking is only requested together with a taken vector
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_result_reg.push_frame)
        |-> (out_result_reg.vector_taken == tciu_pkg::VEC_OCR
             || out_result_reg.vector_taken == tciu_pkg::VEC_NMI))
        else $error("push_frame without a taken vector");

    // A held beat that is not processed stays in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("held input beat lost or changed");

endmodule

`default_nettype wire

/* verif/timer_compare_interrupt_unit_tb.sv */
// Self-checking testbench for the timer compare interrupt unit: shadow model, stimulus, checks.
`timescale 1ns / 1ps

// Shadow of the timer and interrupt state: predicts one result beat per input beat
class timer_slot_model;
    logic [7:0]  tctl;
    logic [15:0] counter;
    logic [15:0] compare;
    logic [7:0]  hi_latch;
    logic [7:0]  t2ctl;
    logic        nmi_pend;
    logic        ocr_pend;
    logic [1:0]  low_power;  // bit 0 waiting, bit 1 sleeping
    tciu_pkg::result_t due_results[$];
    int          mismatches;
    int          checked;
    int          ocr_taken;
    int          nmi_taken;

    function new();
        tctl       = tciu_pkg::TCTL_RESET;
        counter    = tciu_pkg::CNT_RESET;
        compare    = tciu_pkg::CMP_RESET;
        hi_latch   = 8'h00;
        t2ctl      = tciu_pkg::T2CTL_RESET;
        nmi_pend   = 1'b0;
        ocr_pend   = 1'b0;
        low_power  = 2'b00;
        mismatches = 0;
        checked    = 0;
        ocr_taken  = 0;
        nmi_taken  = 0;
    endfunction

    // Apply one accepted input beat to the shadow state and queue its result
    function void note_slot(tciu_pkg::item_t it);
        tciu_pkg::result_t r;
        logic [3:0] cyc_in;
        logic [15:0] sum;
        r = '0;
        cyc_in = (it.instr_cycles > tciu_pkg::MAX_CYCLES) ? tciu_pkg::MAX_CYCLES
                                                          : it.instr_cycles;
        case (it.kind)
            tciu_pkg::KIND_STEP: begin
                if ((nmi_pend || ocr_pend) && !it.irq_masked) begin
                    // compare interrupt wins over NMI
                    if (ocr_pend) begin
                        ocr_pend = 1'b0;
                        r.vector_taken = tciu_pkg::VEC_OCR;
                        ocr_taken++;
                    end
                    else begin
                        nmi_pend = 1'b0;
                        r.vector_taken = tciu_pkg::VEC_NMI;
                        nmi_taken++;
                    end
                    // sleep always ends; frame is stacked only if not waiting
                    low_power[1] = 1'b0;
                    if (low_power != 2'b00)
                        low_power = 2'b00;
                    else
                        r.push_frame = 1'b1;
                    r.cycles_used = 4'd1;
                end
                else if (low_power != 2'b00) begin
                    r.cycles_used = 4'd1;
                end
                else begin
                    r.run_instruction = 1'b1;
                    r.cycles_used = cyc_in;
                end
                // counter advance, wraps at 16 bits before the compare
                if (tctl[tciu_pkg::TCTL_ENABLE_BIT]) begin
                    sum = counter + 16'(r.cycles_used);
                    if (sum >= compare) begin
                        sum = sum - compare;
                        ocr_pend = 1'b1;
                    end
                    counter = sum;
                end
            end
            tciu_pkg::KIND_CTL_WR:
                tctl = (it.data & tciu_pkg::TCTL_WR_MASK) | (tctl & tciu_pkg::TCTL_KEEP_MASK);
            tciu_pkg::KIND_CNT_HI_WR: begin
                hi_latch = it.data;
                counter = tciu_pkg::CNT_HI_PRESET;
            end
            tciu_pkg::KIND_CNT_LO_WR: counter = {hi_latch, it.data};
            tciu_pkg::KIND_CNT_HI_RD: begin
                tctl = tctl & tciu_pkg::TCTL_RD_MASK;
                r.read_data = counter[15:8];
            end
            tciu_pkg::KIND_NMI:       nmi_pend = 1'b1;
            tciu_pkg::KIND_CMP_HI_WR: compare[15:8] = it.data;
            tciu_pkg::KIND_CMP_LO_WR: compare[7:0] = it.data;
            tciu_pkg::KIND_CMP_ACK:   compare = compare & tciu_pkg::CMP_ACK_MASK;
            tciu_pkg::KIND_WAIT:      low_power[0] = 1'b1;
            tciu_pkg::KIND_SLEEP:     low_power[1] = 1'b1;
            // timer 2 keeps the same upper bits as the main control register
            tciu_pkg::KIND_T2_CTL_WR:
                t2ctl = (it.data & tciu_pkg::T2CTL_WR_MASK) | tciu_pkg::T2CTL_SET
                      | (t2ctl & tciu_pkg::TCTL_KEEP_MASK);
            default: ;
        endcase
        r.compare_pending = ocr_pend;
        r.nmi_pending_out = nmi_pend;
        due_results.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("field %s: expected 'h%0h, actual 'h%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare one output beat against the oldest queued result
    function void check_slot(logic [23:0] beat);
        tciu_pkg::result_t want;
        if (due_results.size() == 0) begin
            $error("output beat 'h%06h arrived with no result queued", beat);
            mismatches++;
            return;
        end
        want = due_results.pop_front();
        checked++;
        check_field("read_data", want.read_data, beat[7:0]);
        check_field("vector_taken", want.vector_taken, beat[9:8]);
        check_field("push_frame", want.push_frame, beat[10]);
        check_field("run_instruction", want.run_instruction, beat[11]);
        check_field("cycles_used", want.cycles_used, beat[15:12]);
        check_field("compare_pending", want.compare_pending, beat[16]);
        check_field("nmi_pending_out", want.nmi_pending_out, beat[17]);
        check_field("pad", 0, beat[23:18]);
    endfunction
endclass

module timer_compare_interrupt_unit_tb;

    localparam int RANDOM_ITEMS   = 1300;
    localparam int HOLD_OFF_BEATS = 80;
    localparam int WATCHDOG_LIMIT = 1000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [23:0] m_axis_tdata;

    timer_slot_model shadow;
    tciu_pkg::item_t slot_plan[$];
    int              burst_left = 0;
    int              beats_sent = 0;
    int              random_count = 0;
    int              idle_cycles = 0;
    bit              hold_off_req = 1'b0;
    bit              held = 1'b0;
    logic [8:0]      rcv_tick = '0;

    timer_compare_interrupt_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            shadow.check_slot(m_axis_tdata);
    end

    // Watchdog: cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: rotating ready pattern, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_BEATS - 1) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                rcv_tick <= rcv_tick + 1'b1;
                case (rcv_tick[8:7])
                    2'd0: m_axis_tready <= 1'b1;
                    2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (rcv_tick[2:0] != 3'd0);
                endcase
            end
        end
    end

    function automatic tciu_pkg::item_t make_item(logic [3:0] kind, logic [7:0] data,
                                                  logic masked, logic [3:0] cycles);
        tciu_pkg::item_t it;
        it.kind = kind;
        it.data = data;
        it.irq_masked = masked;
        it.instr_cycles = cycles;
        return it;
    endfunction

    // register access with don't-care step fields randomized
    function automatic tciu_pkg::item_t reg_item(logic [3:0] kind, logic [7:0] data);
        return make_item(kind, data, 1'($urandom), 4'($urandom));
    endfunction

    function automatic tciu_pkg::item_t random_step();
        logic [3:0] cyc;
        cyc = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 12));
        return make_item(tciu_pkg::KIND_STEP, 8'($urandom), ($urandom_range(0, 3) == 0),
                         cyc);
    endfunction

    function automatic tciu_pkg::item_t random_any();
        return make_item(4'($urandom_range(0, 15)), 8'($urandom), 1'($urandom), 4'($urandom));
    endfunction

    // One random scenario: a short setup followed by a run of mostly steps, or a run of random items
    function automatic void plan_segment();
        int         n;
        logic [7:0] d;
        bit         noise;
        noise = 1'b0;
        case ($urandom_range(0, 4))
            0: begin
                // usually enable the counter, mostly with a compare value it will reach soon
                d = 8'($urandom);
                if ($urandom_range(0, 4) != 0)
                    d[tciu_pkg::TCTL_ENABLE_BIT] = 1'b1;
                slot_plan.push_back(reg_item(tciu_pkg::KIND_CTL_WR, d));
                slot_plan.push_back(reg_item(tciu_pkg::KIND_CMP_HI_WR,
                    ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00));
                slot_plan.push_back(reg_item(tciu_pkg::KIND_CMP_LO_WR, 8'($urandom)));
                n = $urandom_range(10, 30);
            end
            1: begin
                // counter load, sometimes left at the preset
                slot_plan.push_back(reg_item(tciu_pkg::KIND_CNT_HI_WR, 8'($urandom)));
                if ($urandom_range(0, 9) < 7)
                    slot_plan.push_back(reg_item(tciu_pkg::KIND_CNT_LO_WR, 8'($urandom)));
                if ($urandom_range(0, 1) == 0)
                    slot_plan.push_back(reg_item(tciu_pkg::KIND_CNT_HI_RD, 8'($urandom)));
                n = $urandom_range(5, 20);
            end
            2: begin
                // low power entry and wake-up
                slot_plan.push_back(reg_item(($urandom_range(0, 1) == 0)
                                             ? tciu_pkg::KIND_WAIT : tciu_pkg::KIND_SLEEP,
                                             8'($urandom)));
                if ($urandom_range(0, 3) == 0)
                    slot_plan.push_back(reg_item(tciu_pkg::KIND_SLEEP, 8'($urandom)));
                if ($urandom_range(0, 2) != 0)
                    slot_plan.push_back(reg_item(tciu_pkg::KIND_NMI, 8'($urandom)));
                n = $urandom_range(3, 10);
            end
            3: begin
                case ($urandom_range(0, 3))
                    0: slot_plan.push_back(reg_item(tciu_pkg::KIND_CMP_ACK, 8'($urandom)));
                    1: slot_plan.push_back(reg_item(tciu_pkg::KIND_T2_CTL_WR, 8'($urandom)));
                    2: slot_plan.push_back(reg_item(tciu_pkg::KIND_CNT_HI_RD, 8'($urandom)));
                    default: slot_plan.push_back(reg_item(tciu_pkg::KIND_NMI, 8'($urandom)));
                endcase
                n = $urandom_range(3, 15);
            end
            default: begin
                noise = 1'b1;
                n = $urandom_range(5, 20);
            end
        endcase
        repeat (n)
            slot_plan.push_back((noise || $urandom_range(0, 9) == 0) ? random_any() : random_step());
    endfunction

    // Offer one beat from a falling edge and return at the falling edge after acceptance
    task automatic drive_beat(input tciu_pkg::item_t it);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, it.instr_cycles, it.irq_masked, it.data};
        s_axis_tuser  <= it.kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        shadow.note_slot(it);
        beats_sent++;
        @(negedge clk);
    endtask

    // Send the planned beats in bursts with random gaps
    task automatic send_plan();
        tciu_pkg::item_t it;
        while (slot_plan.size() > 0)
        begin
            it = slot_plan.pop_front();
            if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 12);
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            burst_left--;
            drive_beat(it);
        end
    endtask

    // Stop offering and wait until every queued result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (shadow.due_results.size() != 0);
    endtask

    initial
    begin
        shadow = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, every kind, interrupt priority and low power cases
        slot_plan.push_back(reg_item(tciu_pkg::KIND_CNT_HI_RD, 8'h00));
        slot_plan.push_back(make_item(tciu_pkg::KIND_STEP, 8'h00, 1'b0, 4'd0));
        slot_plan.push_back(make_item(tciu_pkg::KIND_STEP, 8'hFF, 1'b0, 4'd15));
        slot_plan.push_back(reg_item(tciu_pkg::KIND_CTL_WR, 8'hFF));
        slot_plan.push_back(reg_item(tciu_pkg::KIND_CMP_HI_WR, 8'h00));
        slot_plan.push_back(reg_item(tciu_pkg::KIND_CMP_LO_WR, 8'h10));
        slot_plan.push_back(make_item(tciu_pkg::KIND_STEP, 8'h00, 1'b0, 4'd12));
        slot_plan.push_back(make_item(tciu_pkg::KIND_STEP, 8'h00, 1'b0, 4'd12));
        slot_plan.push_back(make_item(tciu_pkg::KIND_STEP, 8'h00, 1'b1, 4'd13));
        slot_plan.push_back(reg_item(tciu_pkg::KIND_NMI, 8'h00));
        slot_plan.push_back(make_item(tciu_pkg::KIND_STEP, 8'h00, 1'b0, 4'd1));
        slot_plan.push_back(make_item(tciu_pkg::KIND_STEP, 8'h00, 1'b0, 4'd1));
        slot_plan.push_back(reg_item(tciu_pkg::KIND_WAIT, 8'h00));
        slot_plan.push_back(reg_item(tciu_pkg::KIND_NMI, 8'h00));
        slot_plan.push_back(make_item(tciu_pkg::KIND_STEP, 8'h00, 1'b0, 4'd5));
        slot_plan.push_back(reg_item(tciu_pkg::KIND_SLEEP, 8'h00));
        slot_plan.push_back(make_item(tciu_pkg::KIND_STEP, 8'h00, 1'b0, 4'd5));
        slot_plan.push_back(reg_item(tciu_pkg::KIND_NMI, 8'h00));
        slot_plan.push_back(make_item(tciu_pkg::KIND_STEP, 8'h00, 1'b0, 4'd5));
        slot_plan.push_back(reg_item(tciu_pkg::KIND_CNT_HI_WR, 8'hAB));
        slot_plan.push_back(make_item(tciu_pkg::KIND_STEP, 8'h00, 1'b1, 4'd12));
        slot_plan.push_back(reg_item(tciu_pkg::KIND_CNT_HI_RD, 8'h00));
        slot_plan.push_back(reg_item(tciu_pkg::KIND_CNT_LO_WR, 8'hCD));
        slot_plan.push_back(reg_item(tciu_pkg::KIND_CMP_HI_WR, 8'hFF));
        slot_plan.push_back(reg_item(tciu_pkg::KIND_CMP_ACK, 8'h00));
        slot_plan.push_back(reg_item(tciu_pkg::KIND_T2_CTL_WR, 8'hFF));
        slot_plan.push_back(reg_item(tciu_pkg::KIND_T2_CTL_WR + 4'd4, 8'hFF));
        send_plan();
        drain();

        // Random scenarios, with one long receiver hold-off halfway through
        while (random_count < RANDOM_ITEMS)
        begin
            if (!held && random_count >= RANDOM_ITEMS / 2)
            begin
                held = 1'b1;
                drain();
                hold_off_req = 1'b1;
                burst_left = 40;
                repeat (30) slot_plan.push_back(random_step());
                random_count += 30;
                send_plan();
            end
            plan_segment();
            foreach (slot_plan[i])
                if (slot_plan[i].kind <= tciu_pkg::KIND_T2_CTL_WR)
                    random_count++;
            send_plan();
        end

        drain();
        repeat (10) @(negedge clk);
        $display("Sent %0d beats; %0d compare and %0d NMI vectors taken",
                 beats_sent, shadow.ocr_taken, shadow.nmi_taken);
        $display("Checked %0d result beats, %0d mismatches",
                 shadow.checked, shadow.mismatches);
        if (shadow.mismatches == 0 && shadow.due_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
